@@ rtl/dls_pkg.sv @@
// shared types and constants for the level-to-sample ring converter
// used by dls_front, dls_cmd_queue, dls_back and dac_level_to_sample_ring
`default_nettype none

package dls_pkg;

    // ring geometry
    localparam int RING_DEPTH = 16384;
    localparam int IDX_W      = $clog2(RING_DEPTH);

    // fill count saturation
    localparam int          PEND_W      = 16;
    localparam logic [15:0] PENDING_MAX = 16'hffff;

    // samples per tick = 1000 / 22050, reduced by their common factor of 50
    localparam int SCALE_NUM = 1000 / 50;
    localparam int SCALE_DEN = 22050 / 50;

    // smallest elapsed count that already yields a full ring of samples
    localparam int ELAPSED_CAP = (RING_DEPTH * SCALE_DEN + SCALE_NUM - 1) / SCALE_NUM;
    localparam int ELAPSED_W   = $clog2(ELAPSED_CAP + 1);
    localparam int ACC_W       = $clog2(ELAPSED_CAP * SCALE_NUM + 1);

    // function codes of an input request
    localparam logic [1:0] FUNC_LEVEL   = 2'd0;
    localparam logic [1:0] FUNC_SPEAKER = 2'd1;
    localparam logic [1:0] FUNC_PULL    = 2'd2;

    typedef enum logic {
        CMD_LEVEL = 1'b0,
        CMD_PULL  = 1'b1
    } cmd_kind_t;

    // work handed from the front to the back
    typedef struct packed {
        cmd_kind_t              kind;
        logic [15:0]            word;
        logic [ELAPSED_W-1:0]   elapsed;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

`default_nettype wire

@@ rtl/dac_level_to_sample_ring.sv @@
// top level of the level-to-sample ring converter
// depends on dls_pkg, dls_front, dls_cmd_queue and dls_back
`default_nettype none

// Input channel (in_valid / in_stall): func 0 sets an 8-bit level, func 1 sets the
// speaker bit (nonzero means level 255), func 2 pulls one sample, func 3 is dropped.
// Each level request carries a tick stamp; the ticks since the previous change,
// scaled by 1000/22050 and capped at the ring depth, give the number of copies of
// the previous level appended to the ring, one ring write per cycle.
// Output channel (out_valid / out_stall): one sample per pull request, with
// was_empty set and zero returned when nothing is pending.
// A level request occupies the back end while its samples are written; a pull
// with nothing pending is answered from the idle state, otherwise its slot is
// read and cleared and the result is registered from the pull state.
// The front and back are joined by a two-entry request queue, so the front keeps
// accepting while the back is busy filling.
// After reset the ring is swept to zero, during which in_stall is held high.
// A stalled result sits in the output register; further pulls wait
// in the queue and the input stalls once the queue is full.

module dac_level_to_sample_ring (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         func,
    input  wire logic [7:0]         level,
    input  wire logic [31:0]        tick_stamp,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      sample,
    output logic                    was_empty
);

    dls_pkg::back_status_t status;
    dls_pkg::cmd_t         push_cmd;
    dls_pkg::cmd_t         pop_cmd;
    logic                  push_valid;
    logic                  q_full;
    logic                  pop_valid;
    logic                  cmd_pop;

    dls_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .level      (level),
        .tick_stamp (tick_stamp),
        .status     (status),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    dls_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop        (cmd_pop)
    );

    dls_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (pop_valid),
        .cmd        (pop_cmd),
        .cmd_pop    (cmd_pop),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample     (sample),
        .was_empty  (was_empty)
    );

endmodule

`default_nettype wire

@@ rtl/dls_front.sv @@
// front end: accepts requests, classifies them and tracks the last level and tick
// depends on dls_pkg
`default_nettype none

module dls_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             func,
    input  wire logic [7:0]             level,
    input  wire logic [31:0]            tick_stamp,
    input  wire dls_pkg::back_status_t  status,
    input  wire logic                   q_full,
    output logic                        push_valid,
    output dls_pkg::cmd_t               push_cmd
);

    logic [31:0] last_tick_reg;
    logic [31:0] last_tick_next;
    logic [7:0]  last_level_reg;
    logic [7:0]  last_level_next;
    logic        accept;
    logic [31:0] diff;
    logic        diff_pos;
    logic [7:0]  new_level;
    logic [dls_pkg::ELAPSED_W-1:0] elapsed;

    assign in_stall = q_full | status.clearing;
    assign accept   = in_valid & ~in_stall;

    assign diff     = tick_stamp - last_tick_reg;
    assign diff_pos = (diff != 32'd0) & ~diff[31];
    assign new_level = (func == dls_pkg::FUNC_SPEAKER) ? {8{level != 8'd0}} : level;

    always_comb
    begin
        if (!diff_pos) begin
            elapsed = '0;
        end else if (diff >= 32'(dls_pkg::ELAPSED_CAP)) begin
            elapsed = dls_pkg::ELAPSED_W'(dls_pkg::ELAPSED_CAP);
        end else begin
            elapsed = diff[dls_pkg::ELAPSED_W-1:0];
        end
    end

    always_comb
    begin
        push_valid       = 1'b0;
        push_cmd.kind    = dls_pkg::CMD_LEVEL;
        // previous level as a signed sample: shift up, flip the top bit
        push_cmd.word    = {~last_level_reg[7], last_level_reg[6:0], 8'h00};
        push_cmd.elapsed = elapsed;
        last_tick_next   = last_tick_reg;
        last_level_next  = last_level_reg;
        if (accept) begin
            case (func)
                dls_pkg::FUNC_LEVEL, dls_pkg::FUNC_SPEAKER:
                begin
                    push_valid      = 1'b1;
                    last_tick_next  = tick_stamp;
                    last_level_next = new_level;
                end
                dls_pkg::FUNC_PULL:
                begin
                    push_valid    = 1'b1;
                    push_cmd.kind = dls_pkg::CMD_PULL;
                end
                default:
                begin
                    push_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_tick_reg  <= '0;
            last_level_reg <= '0;
        end else begin
            last_tick_reg  <= last_tick_next;
            last_level_reg <= last_level_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dls_cmd_queue.sv @@
// two-entry queue of commands between the front and the back
// depends on dls_pkg
`default_nettype none

module dls_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    input  wire dls_pkg::cmd_t  push_cmd,
    output logic                full,
    output logic                pop_valid,
    output dls_pkg::cmd_t       pop_cmd,
    input  wire logic           pop
);

    dls_pkg::cmd_t entry_reg [2];
    logic       head_reg;
    logic       head_next;
    logic       tail_reg;
    logic       tail_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full      = count_reg == 2'd2;
    assign pop_valid = count_reg != 2'd0;
    assign pop_cmd   = entry_reg[head_reg];
    assign do_push   = push_valid & ~full;
    assign do_pop    = pop & pop_valid;

    always_comb
    begin
        head_next  = do_pop  ? ~head_reg : head_reg;
        tail_next  = do_push ? ~tail_reg : tail_reg;
        count_next = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[tail_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dls_back.sv @@
// back end: sample ring memory, fill and pull sequencer, result register
// depends on dls_pkg
`default_nettype none

module dls_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    input  wire dls_pkg::cmd_t         cmd,
    output logic                       cmd_pop,
    output dls_pkg::back_status_t      status,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [15:0]         sample,
    output logic                       was_empty
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_FILL  = 4'b0100,
        S_PULL  = 4'b1000
    } state_t;

    localparam logic [dls_pkg::IDX_W-1:0] IDX_LAST = dls_pkg::IDX_W'(dls_pkg::RING_DEPTH - 1);
    localparam logic [dls_pkg::ACC_W-1:0] ACC_STEP = dls_pkg::ACC_W'(dls_pkg::SCALE_DEN);

    logic [15:0] ring_mem [dls_pkg::RING_DEPTH];

    state_t                     state_reg;
    state_t                     state_next;
    logic [dls_pkg::IDX_W-1:0]  wr_idx_reg;
    logic [dls_pkg::IDX_W-1:0]  wr_idx_next;
    logic [dls_pkg::IDX_W-1:0]  rd_idx_reg;
    logic [dls_pkg::IDX_W-1:0]  rd_idx_next;
    logic [dls_pkg::PEND_W-1:0] pending_reg;
    logic [dls_pkg::PEND_W-1:0] pending_next;
    logic [dls_pkg::ACC_W-1:0]  acc_reg;
    logic [dls_pkg::ACC_W-1:0]  acc_next;
    logic [15:0]                word_reg;
    logic [15:0]                word_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [15:0]                sample_reg;
    logic [15:0]                sample_next;
    logic                       was_empty_reg;
    logic                       was_empty_next;
    logic [15:0]                rd_data_reg;

    logic                       mem_we;
    logic                       mem_re;
    logic [dls_pkg::IDX_W-1:0]  mem_addr;
    logic [15:0]                mem_wdata;
    logic                       out_free;

    assign out_valid       = out_valid_reg;
    assign sample          = sample_reg;
    assign was_empty       = was_empty_reg;
    assign status.clearing = state_reg == S_CLEAR;
    assign out_free        = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        state_next     = state_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        pending_next   = pending_reg;
        acc_next       = acc_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg & out_stall;
        sample_next    = sample_reg;
        was_empty_next = was_empty_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = wr_idx_reg;
        mem_wdata      = 16'h0000;

        case (state_reg)
            S_CLEAR:
            begin
                // zero sweep after reset, write index ends back at zero
                mem_we      = 1'b1;
                wr_idx_next = (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + 1'b1;
                if (wr_idx_reg == IDX_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid) begin
                    if (cmd.kind == dls_pkg::CMD_LEVEL) begin
                        cmd_pop    = 1'b1;
                        acc_next   = dls_pkg::ACC_W'(cmd.elapsed) *
                                     dls_pkg::ACC_W'(dls_pkg::SCALE_NUM);
                        word_next  = cmd.word;
                        state_next = S_FILL;
                    end else if (out_free) begin
                        cmd_pop = 1'b1;
                        if (pending_reg == '0) begin
                            out_valid_next = 1'b1;
                            sample_next    = 16'h0000;
                            was_empty_next = 1'b1;
                        end else begin
                            // read the slot and clear it in the same cycle
                            mem_re       = 1'b1;
                            mem_we       = 1'b1;
                            mem_addr     = rd_idx_reg;
                            rd_idx_next  = (rd_idx_reg == IDX_LAST) ? '0 : rd_idx_reg + 1'b1;
                            pending_next = pending_reg - 1'b1;
                            state_next   = S_PULL;
                        end
                    end
                end
            end
            S_FILL:
            begin
                // one sample per step of the scaled elapsed count
                if (acc_reg >= ACC_STEP) begin
                    mem_we       = 1'b1;
                    mem_wdata    = word_reg;
                    wr_idx_next  = (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + 1'b1;
                    acc_next     = acc_reg - ACC_STEP;
                    if (pending_reg != dls_pkg::PENDING_MAX) begin
                        pending_next = pending_reg + 1'b1;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_PULL:
            begin
                out_valid_next = 1'b1;
                sample_next    = rd_data_reg;
                was_empty_next = 1'b0;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            pending_reg   <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            pending_reg   <= pending_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        sample_reg    <= sample_next;
        was_empty_reg <= was_empty_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            ring_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= ring_mem[mem_addr];
        end
    end

endmodule

`default_nettype wire

@@ test/dls_ring_checker.sv @@
`timescale 1ns / 100ps
// checker for the level-to-sample ring converter: watches both request channels,
// keeps its own copy of the ring and compares every returned sample in order
// depends on dls_pkg for the ring size, fill limit and function codes

module dls_ring_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [1:0]         func,
    input  wire logic [7:0]         level,
    input  wire logic [31:0]        tick_stamp,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic signed [15:0] sample,
    input  wire logic               was_empty,
    output int                      mismatches,
    output int                      results_due
);

    localparam logic [63:0] SCALE_MUL  = 64'd1000;
    localparam logic [63:0] SCALE_DIV  = 64'd22050;
    localparam logic [15:0] SIGN_FLIP  = 16'h8000;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               was_empty;
    } pulled_sample_t;

    pulled_sample_t   expected_pulls[$];

    logic [15:0]                ring_copy [dls_pkg::RING_DEPTH];
    logic [dls_pkg::IDX_W-1:0]  wr_ptr;
    logic [dls_pkg::IDX_W-1:0]  rd_ptr;
    logic [dls_pkg::PEND_W-1:0] fill_level;
    logic [31:0]                prev_tick;
    logic [7:0]                 prev_level;

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [31:0]    elapsed;
        logic [63:0]    copies;
        logic [31:0]    filled;
        logic [15:0]    held_word;
        logic [7:0]     next_level;
        pulled_sample_t want;
        int             k;
        if (!rst_n)
        begin
            for (k = 0; k < dls_pkg::RING_DEPTH; k++)
                ring_copy[k] = '0;
            wr_ptr      = '0;
            rd_ptr      = '0;
            fill_level  = '0;
            prev_tick   = '0;
            prev_level  = '0;
            expected_pulls.delete();
            mismatches  = 0;
            results_due = 0;
        end
        else
        begin
            // results first, so a pull taken on this edge never meets its own result
            if (out_valid && !out_stall)
            begin
                if (expected_pulls.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result expected none got sample %h was_empty %b",
                             $time, sample, was_empty);
                end
                else
                begin
                    want = expected_pulls.pop_front();
                    if (sample !== want.sample)
                    begin
                        mismatches++;
                        $display("%0t: sample expected %h got %h",
                                 $time, want.sample, sample);
                    end
                    if (was_empty !== want.was_empty)
                    begin
                        mismatches++;
                        $display("%0t: was_empty expected %b got %b",
                                 $time, want.was_empty, was_empty);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                case (func)
                    dls_pkg::FUNC_LEVEL, dls_pkg::FUNC_SPEAKER:
                    begin
                        if (func == dls_pkg::FUNC_LEVEL)
                            next_level = level;
                        else
                            next_level = (level != 8'h00) ? 8'hff : 8'h00;
                        elapsed = tick_stamp - prev_tick;
                        // zero or wrapped-negative elapsed time writes nothing
                        if (elapsed != 32'd0 && !elapsed[31])
                        begin
                            copies = ({32'd0, elapsed} * SCALE_MUL) / SCALE_DIV;
                            if (copies > dls_pkg::RING_DEPTH)
                                copies = dls_pkg::RING_DEPTH;
                            held_word = {prev_level, 8'h00} ^ SIGN_FLIP;
                            for (k = 0; k < copies; k++)
                            begin
                                ring_copy[wr_ptr] = held_word;
                                if (wr_ptr == dls_pkg::RING_DEPTH - 1)
                                    wr_ptr = '0;
                                else
                                    wr_ptr++;
                            end
                            filled = {16'd0, fill_level} + copies[31:0];
                            if (filled > dls_pkg::PENDING_MAX)
                                fill_level = dls_pkg::PENDING_MAX;
                            else
                                fill_level = filled[15:0];
                        end
                        prev_level = next_level;
                        prev_tick  = tick_stamp;
                    end
                    dls_pkg::FUNC_PULL:
                    begin
                        if (fill_level != '0)
                        begin
                            want.sample    = ring_copy[rd_ptr];
                            want.was_empty = 1'b0;
                            ring_copy[rd_ptr] = '0;
                            if (rd_ptr == dls_pkg::RING_DEPTH - 1)
                                rd_ptr = '0;
                            else
                                rd_ptr++;
                            fill_level--;
                        end
                        else
                        begin
                            want.sample    = '0;
                            want.was_empty = 1'b1;
                        end
                        expected_pulls.push_back(want);
                    end
                    default:
                    begin
                    end
                endcase
            end
            results_due = expected_pulls.size();
        end
    end

endmodule

@@ test/dac_level_to_sample_ring_tb.sv @@
`timescale 1ns / 100ps
// stimulus and verdict for the level-to-sample ring converter
// depends on dls_pkg, dac_level_to_sample_ring and dls_ring_checker

module dac_level_to_sample_ring_tb;

    localparam logic [1:0] FUNC_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS  = 60;
    localparam int         FINAL_PULLS   = 16;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         LIMIT_NS      = 100_000_000;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic [1:0]         func       = dls_pkg::FUNC_LEVEL;
    logic [7:0]         level      = 8'h00;
    logic [31:0]        tick_stamp = 32'h0;
    logic               out_stall  = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic signed [15:0] sample;
    logic               was_empty;

    int          fail_count;
    int          results_due;
    bit          idling_on  = 1'b1;
    int          in_calm    = 0;
    int          out_calm   = 0;
    int          stall_left = 0;
    logic [31:0] sent_tick  = 32'h0;

    dac_level_to_sample_ring dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .level      (level),
        .tick_stamp (tick_stamp),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample     (sample),
        .was_empty  (was_empty)
    );

    dls_ring_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .level       (level),
        .tick_stamp  (tick_stamp),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample),
        .was_empty   (was_empty),
        .mismatches  (fail_count),
        .results_due (results_due)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver back-pressure in bursts, with calm stretches after some of them
    always @(negedge clk)
    begin
        if (!idling_on)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_calm > 0)
                out_calm--;
            else if ($urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 9);
                if ($urandom_range(0, 2) == 0)
                    out_calm = $urandom_range(10, 40);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic [1:0] code, input logic [7:0] lv,
                                input logic [31:0] ts);
        if (idling_on)
        begin
            if (in_calm > 0)
                in_calm--;
            else if ($urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                if ($urandom_range(0, 2) == 0)
                    in_calm = $urandom_range(5, 25);
            end
        end
        in_valid   <= 1'b1;
        func       <= code;
        level      <= lv;
        tick_stamp <= ts;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_change(input logic [1:0] code, input logic [7:0] lv,
                               input logic [31:0] ts);
        sent_tick = ts;
        send_request(code, lv, ts);
    endtask

    initial
    begin : stimulus
        int          pick;
        int          step;
        int          random_sent;
        logic [1:0]  code;
        logic [7:0]  lv;
        random_sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty pull, zero, short, negative and half-range elapsed times,
        // tick counter wrap, speaker bit values and the unused code
        send_request(dls_pkg::FUNC_PULL, 8'h00, 32'h0);
        send_change(dls_pkg::FUNC_LEVEL, 8'hff, 32'd0);
        send_change(dls_pkg::FUNC_LEVEL, 8'h00, 32'd441);
        send_change(dls_pkg::FUNC_SPEAKER, 8'h80, 32'd463);
        send_change(dls_pkg::FUNC_SPEAKER, 8'h00, 32'd486);
        repeat (3) send_request(dls_pkg::FUNC_PULL, 8'hff, 32'hffff_ffff);
        send_change(dls_pkg::FUNC_LEVEL, 8'h5a, 32'hffff_ffff);
        send_change(dls_pkg::FUNC_SPEAKER, 8'h01, 32'd100);
        send_change(dls_pkg::FUNC_LEVEL, 8'ha5, 32'h8000_0064);
        send_request(FUNC_UNUSED, 8'hff, 32'h0);
        send_change(dls_pkg::FUNC_LEVEL, 8'h33, 32'h8000_0091);
        repeat (10) send_request(dls_pkg::FUNC_PULL, 8'h00, 32'h0);

        // random: pulls roughly keep pace with short level changes so the ring
        // fills and empties; jumps past half range scramble the tick bits
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 48)
            begin
                send_request(dls_pkg::FUNC_PULL, 8'($urandom), $urandom);
                random_sent++;
            end
            else if (pick < 97)
            begin
                code = $urandom_range(0, 1) ? dls_pkg::FUNC_SPEAKER : dls_pkg::FUNC_LEVEL;
                if (code == dls_pkg::FUNC_SPEAKER && $urandom_range(0, 1) == 0)
                    lv = 8'h00;
                else
                    lv = 8'($urandom_range(0, 255));
                if (pick < 82)
                begin
                    if ($urandom_range(0, 15) == 0)
                        step = $urandom_range(51, 600);
                    else
                        step = $urandom_range(1, 50);
                    send_change(code, lv, sent_tick + step);
                end
                else if (pick < 90)
                    send_change(code, lv, sent_tick - $urandom_range(0, 1000));
                else
                    send_change(code, lv,
                                sent_tick + 32'h8000_0000 + $urandom_range(0, 32'h7fff_ffff));
                random_sent++;
            end
            else
                send_request(FUNC_UNUSED, 8'($urandom), $urandom);
        end

        // last part, no idling: largest positive elapsed time and full-ring fills
        // until the fill count saturates, then a short run of pulls
        idling_on = 1'b0;
        send_change(dls_pkg::FUNC_LEVEL, 8'($urandom), sent_tick + 32'h7fff_ffff);
        repeat (3)
            send_change($urandom_range(0, 1) ? dls_pkg::FUNC_SPEAKER : dls_pkg::FUNC_LEVEL,
                        8'($urandom), sent_tick + 32'd400000);
        repeat (FINAL_PULLS)
            send_request(dls_pkg::FUNC_PULL, 8'($urandom), $urandom);
        in_valid <= 1'b0;

        while (results_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
